/* hw/rtl/pfa_pkg.sv */
// Shared types and constants for the partition fit allocator.
// Used by pfa_cell and partition_fit_allocator_core; no dependencies.
package pfa_pkg;

  localparam int unsigned DEF_MAX_PARTITIONS = 16;
  localparam int unsigned ADDR_BITS          = 20;
  localparam int unsigned SIZE_W             = 21;
  localparam int unsigned OWNER_W            = 16;
  localparam int unsigned CFG_W              = 21;
  localparam int unsigned DEF_MEMORY_SIZE    = 4096;

  localparam logic [1:0] REG_FIT_POLICY     = 2'd0;
  localparam logic [1:0] REG_DYNAMIC_SCHEME = 2'd1;
  localparam logic [1:0] REG_MEMORY_SIZE    = 2'd2;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_APPEND = 2'd1,
    OP_ALLOC  = 2'd2,
    OP_FREE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NO_FIT    = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_INIT_DYN,
    CMD_INIT_FIX,
    CMD_APPEND,
    CMD_ALLOC,
    CMD_SPLIT,
    CMD_FREE,
    CMD_MERGE_N,
    CMD_MERGE_P,
    CMD_MERGE_B
  } cmd_kind_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [SIZE_W-1:0]    size;
    logic [OWNER_W-1:0]   owner;
    logic                 used;
  } entry_t;

  typedef struct packed {
    op_t                op;
    logic [1:0]         policy;
    logic [SIZE_W-1:0]  req;
    logic [OWNER_W-1:0] pid;
  } scan_t;

  // search word passed along the row of cells
  typedef struct packed {
    logic                 found;
    logic                 need_next;
    logic [ADDR_BITS-1:0] pbase;
    logic [SIZE_W-1:0]    psize;
    logic                 prev_free;
    logic [SIZE_W-1:0]    prev_size;
    logic                 next_free;
    logic [SIZE_W-1:0]    next_size;
    logic                 lvalid;
    logic                 lused;
    logic [ADDR_BITS-1:0] lbase;
    logic [SIZE_W-1:0]    lsize;
  } token_t;

  typedef struct packed {
    cmd_kind_t          kind;
    entry_t             new_e;
    logic [SIZE_W-1:0]  req;
    logic [OWNER_W-1:0] pid;
    logic [SIZE_W-1:0]  sum_size;
  } cmd_t;

endpackage

/* hw/rtl/pfa_cell.sv */
// One table entry of the partition allocator with its stage of the search chain.
// Depends on pfa_pkg.
module pfa_cell #(
  parameter int MAX_PARTITIONS = pfa_pkg::DEF_MAX_PARTITIONS,
  parameter int CELL_INDEX     = 0,
  localparam int IDXW = $clog2(MAX_PARTITIONS),
  localparam int CW   = $clog2(MAX_PARTITIONS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CW-1:0]     count,
  input  pfa_pkg::scan_t    scan,
  input  pfa_pkg::token_t   tok_in,
  input  logic [IDXW-1:0]   pos_in,
  output pfa_pkg::token_t   tok_out,
  output logic [IDXW-1:0]   pos_out,
  input  pfa_pkg::cmd_t     cmd,
  input  logic [IDXW-1:0]   idx,
  input  pfa_pkg::entry_t   left_e,
  input  pfa_pkg::entry_t   right1_e,
  input  pfa_pkg::entry_t   right2_e,
  output pfa_pkg::entry_t   entry_out
);
  import pfa_pkg::*;

  entry_t          e_r, e_nxt;
  token_t          tok_r, tok_nxt;
  logic [IDXW-1:0] pos_r, pos_nxt;
  logic            valid, fit, own, take;

  assign valid = CELL_INDEX < int'(count);
  assign fit   = valid && !e_r.used && (scan.req <= e_r.size);
  assign own   = valid && e_r.used && (e_r.owner == scan.pid);

  always_comb begin
    tok_nxt = tok_in;
    pos_nxt = pos_in;
    take    = 1'b0;
    case (scan.op)
      OP_ALLOC: begin
        if (fit) begin
          if (!tok_in.found) take = 1'b1;
          else if (scan.policy == POL_BEST && e_r.size < tok_in.psize) take = 1'b1;
          else if (scan.policy == POL_WORST && e_r.size > tok_in.psize) take = 1'b1;
        end
      end
      OP_FREE: begin
        if (own && !tok_in.found) begin
          take              = 1'b1;
          tok_nxt.prev_free = tok_in.lvalid && !tok_in.lused;
          tok_nxt.prev_size = tok_in.lsize;
          tok_nxt.need_next = 1'b1;
        end else if (tok_in.need_next) begin
          tok_nxt.need_next = 1'b0;
          tok_nxt.next_free = valid && !e_r.used;
          tok_nxt.next_size = e_r.size;
        end
      end
      default: ;
    endcase
    if (take) begin
      tok_nxt.found = 1'b1;
      tok_nxt.pbase = e_r.base;
      tok_nxt.psize = e_r.size;
      pos_nxt       = IDXW'(CELL_INDEX);
    end
    if (valid) begin
      tok_nxt.lvalid = 1'b1;
      tok_nxt.lused  = e_r.used;
      tok_nxt.lbase  = e_r.base;
      tok_nxt.lsize  = e_r.size;
    end
  end

  always_comb begin
    int ix;
    ix    = int'(idx);
    e_nxt = e_r;
    case (cmd.kind)
      CMD_INIT_DYN: begin
        e_nxt.used = 1'b0;
        if (CELL_INDEX == 0) e_nxt = cmd.new_e;
      end
      CMD_INIT_FIX: e_nxt.used = 1'b0;
      CMD_APPEND: if (CELL_INDEX == ix) e_nxt = cmd.new_e;
      CMD_ALLOC: begin
        if (CELL_INDEX == ix) begin
          e_nxt.used  = 1'b1;
          e_nxt.owner = cmd.pid;
        end
      end
      CMD_SPLIT: begin
        if (CELL_INDEX == ix) begin
          e_nxt.size  = cmd.req;
          e_nxt.used  = 1'b1;
          e_nxt.owner = cmd.pid;
        end else if (CELL_INDEX == ix + 1) begin
          e_nxt = cmd.new_e;
        end else if (CELL_INDEX > ix + 1) begin
          e_nxt = left_e;
        end
      end
      CMD_FREE: if (CELL_INDEX == ix) e_nxt.used = 1'b0;
      CMD_MERGE_N: begin
        if (CELL_INDEX == ix) begin
          e_nxt.size = cmd.sum_size;
          e_nxt.used = 1'b0;
        end else if (CELL_INDEX > ix) begin
          e_nxt = right1_e;
        end
      end
      CMD_MERGE_P: begin
        if (CELL_INDEX == ix - 1) e_nxt.size = cmd.sum_size;
        else if (CELL_INDEX >= ix) e_nxt = right1_e;
      end
      CMD_MERGE_B: begin
        if (CELL_INDEX == ix - 1) e_nxt.size = cmd.sum_size;
        else if (CELL_INDEX >= ix) e_nxt = right2_e;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r.used <= 1'b0;
    end else begin
      e_r <= e_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    pos_r <= pos_nxt;
  end

  assign tok_out   = tok_r;
  assign pos_out   = pos_r;
  assign entry_out = e_r;

endmodule

/* hw/rtl/partition_fit_allocator_core.sv */
// Partition table allocator: control, configuration registers and the row of cells.
// Depends on pfa_pkg and pfa_cell.
//
// Use: pulse start with in_operation, in_request_size and in_process_id while
// busy is low; the word is taken at that edge. busy then stays high while a
// search word walks the row of MAX_PARTITIONS cells, one cell a cycle, and
// then the apply state updates every cell at once (shifts for insert and
// remove happen in that state).
// Result: out_valid is high for one cycle, registered in the apply state;
// busy is low again in that same cycle, so a new start may be given then.
// A new word is taken only once busy is low, after the last one is through.
// The result word cannot be held off: out_valid marks the only cycle in
// which out_status, out_granted_base and out_granted_size are meaningful.
// Configuration: cfg_we writes cfg_data into register cfg_index at once;
// write only while busy is low.
// Reset (rst_n low, synchronous) empties the table, returns to idle and
// restores first fit, dynamic scheme and a memory size of 4096.
module partition_fit_allocator_core #(
  parameter int MAX_PARTITIONS = pfa_pkg::DEF_MAX_PARTITIONS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_operation,
  input  logic [pfa_pkg::SIZE_W-1:0]     in_request_size,
  input  logic [pfa_pkg::OWNER_W-1:0]    in_process_id,
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [pfa_pkg::ADDR_BITS-1:0]  out_granted_base,
  output logic [pfa_pkg::SIZE_W-1:0]     out_granted_size,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [pfa_pkg::CFG_W-1:0]      cfg_data
);
  import pfa_pkg::*;

  localparam int IDXW = $clog2(MAX_PARTITIONS);
  localparam int CW   = $clog2(MAX_PARTITIONS + 1);

  state_t             state_r, state_nxt;
  logic [IDXW-1:0]    cnt_r, cnt_nxt;
  op_t                op_r;
  logic [SIZE_W-1:0]  req_r;
  logic [OWNER_W-1:0] pid_r;
  logic [CW-1:0]      count_r, count_nxt;

  logic [1:0]         policy_r;
  logic               dyn_r;
  logic [SIZE_W-1:0]  memsize_r;

  logic                 out_valid_r, out_valid_nxt;
  status_t              status_r, status_nxt;
  logic [ADDR_BITS-1:0] gbase_r, gbase_nxt;
  logic [SIZE_W-1:0]    gsize_r, gsize_nxt;

  cmd_t               cmd;
  logic [IDXW-1:0]    idx;
  scan_t              scan;
  token_t             tok  [MAX_PARTITIONS+1];
  logic [IDXW-1:0]    pos  [MAX_PARTITIONS+1];
  entry_t             ent  [MAX_PARTITIONS];
  token_t             res;
  logic               full, split;
  logic [SIZE_W+1:0]  sum3;
  logic [SIZE_W:0]    addr_sum;

  assign scan.op     = op_r;
  assign scan.policy = policy_r;
  assign scan.req    = req_r;
  assign scan.pid    = pid_r;
  assign tok[0]      = '0;
  assign pos[0]      = '0;
  assign res         = tok[MAX_PARTITIONS];

  for (genvar g = 0; g < MAX_PARTITIONS; g++) begin : g_cell
    pfa_cell #(
      .MAX_PARTITIONS(MAX_PARTITIONS),
      .CELL_INDEX    (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .count    (count_r),
      .scan     (scan),
      .tok_in   (tok[g]),
      .pos_in   (pos[g]),
      .tok_out  (tok[g+1]),
      .pos_out  (pos[g+1]),
      .cmd      (cmd),
      .idx      (idx),
      .left_e   (ent[(g > 0) ? g - 1 : 0]),
      .right1_e (ent[(g + 1 < MAX_PARTITIONS) ? g + 1 : MAX_PARTITIONS - 1]),
      .right2_e (ent[(g + 2 < MAX_PARTITIONS) ? g + 2 : MAX_PARTITIONS - 1]),
      .entry_out(ent[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r  <= POL_FIRST;
      dyn_r     <= 1'b1;
      memsize_r <= SIZE_W'(DEF_MEMORY_SIZE);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIT_POLICY:     policy_r  <= cfg_data[1:0];
        REG_DYNAMIC_SCHEME: dyn_r     <= cfg_data[0];
        REG_MEMORY_SIZE:    memsize_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
          cnt_nxt   = '0;
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (int'(cnt_r) == MAX_PARTITIONS - 1) state_nxt = S_APPLY;
      end
      S_APPLY: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign full     = int'(count_r) >= MAX_PARTITIONS;
  assign split    = dyn_r && (res.psize > req_r);
  assign addr_sum = {1'b0, res.lbase} + (SIZE_W + 1)'(res.lsize);

  always_comb begin
    sum3 = (SIZE_W + 2)'(res.psize)
         + (SIZE_W + 2)'(res.prev_free ? res.prev_size : '0)
         + (SIZE_W + 2)'(res.next_free ? res.next_size : '0);
  end

  always_comb begin
    cmd           = '0;
    cmd.kind      = CMD_NONE;
    cmd.req       = req_r;
    cmd.pid       = pid_r;
    cmd.sum_size  = (sum3 > (SIZE_W + 2)'({SIZE_W{1'b1}})) ? {SIZE_W{1'b1}}
                                                            : sum3[SIZE_W-1:0];
    idx           = pos[MAX_PARTITIONS];
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    status_nxt    = STS_OK;
    gbase_nxt     = '0;
    gsize_nxt     = '0;
    if (state_r == S_APPLY) begin
      out_valid_nxt = 1'b1;
      case (op_r)
        OP_INIT: begin
          cmd.new_e.base = '0;
          cmd.new_e.size = memsize_r;
          if (dyn_r) begin
            cmd.kind  = CMD_INIT_DYN;
            count_nxt = CW'(1);
            gsize_nxt = memsize_r;
          end else begin
            cmd.kind  = CMD_INIT_FIX;
            count_nxt = '0;
          end
        end
        OP_APPEND: begin
          if (full) begin
            status_nxt = STS_FULL;
          end else begin
            cmd.kind       = CMD_APPEND;
            idx            = count_r[IDXW-1:0];
            cmd.new_e.base = res.lvalid ? addr_sum[ADDR_BITS-1:0] : '0;
            cmd.new_e.size = req_r;
            count_nxt      = count_r + 1'b1;
            gbase_nxt      = cmd.new_e.base;
            gsize_nxt      = req_r;
          end
        end
        OP_ALLOC: begin
          if (!res.found) begin
            status_nxt = STS_NO_FIT;
          end else if (split && full) begin
            status_nxt = STS_FULL;
          end else begin
            cmd.new_e.base = res.pbase + ADDR_BITS'(req_r);
            cmd.new_e.size = res.psize - req_r;
            gbase_nxt      = res.pbase;
            if (split) begin
              cmd.kind  = CMD_SPLIT;
              count_nxt = count_r + 1'b1;
              gsize_nxt = req_r;
            end else begin
              cmd.kind  = CMD_ALLOC;
              gsize_nxt = res.psize;
            end
          end
        end
        OP_FREE: begin
          if (!res.found) begin
            status_nxt = STS_NOT_FOUND;
          end else begin
            gbase_nxt = res.pbase;
            gsize_nxt = res.psize;
            cmd.kind  = CMD_FREE;
            if (dyn_r) begin
              if (res.prev_free && res.next_free) begin
                cmd.kind  = CMD_MERGE_B;
                count_nxt = count_r - CW'(2);
              end else if (res.next_free) begin
                cmd.kind  = CMD_MERGE_N;
                count_nxt = count_r - 1'b1;
              end else if (res.prev_free) begin
                cmd.kind  = CMD_MERGE_P;
                count_nxt = count_r - 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    status_r <= status_nxt;
    gbase_r  <= gbase_nxt;
    gsize_r  <= gsize_nxt;
    if (state_r == S_IDLE && start) begin
      op_r  <= op_t'(in_operation);
      req_r <= in_request_size;
      pid_r <= in_process_id;
    end
  end

  assign busy             = state_r != S_IDLE;
  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_granted_base = gbase_r;
  assign out_granted_size = gsize_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= MAX_PARTITIONS)
    else $error("entry count beyond table depth");
  a_valid_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_APPLY)
    else $error("result word without an apply cycle");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");
  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> $stable(count_r))
    else $error("entry count moved during search");
`endif

endmodule

/* dv/testbench.sv */
// Self-checking testbench for partition_fit_allocator_core: directed table plus random
// command words, each result checked against a behavioural model of the partition table.
// Depends on pfa_pkg and the RTL of partition_fit_allocator_core.
module testbench;
  import pfa_pkg::*;

  localparam int NPART = 16;
  localparam int LIMIT = 400000;
  localparam logic [SIZE_W-1:0] SZ_MAX = {SIZE_W{1'b1}};

  typedef struct packed {
    status_t              st;
    logic [ADDR_BITS-1:0] base;
    logic [SIZE_W-1:0]    size;
  } grant_t;

  typedef struct {
    op_t                  op;
    logic [SIZE_W-1:0]    req;
    logic [OWNER_W-1:0]   pid;
    bit                   typed;
    grant_t               want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_operation = '0;
  logic [SIZE_W-1:0] in_request_size = '0;
  logic [OWNER_W-1:0] in_process_id = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [ADDR_BITS-1:0] out_granted_base;
  logic [SIZE_W-1:0] out_granted_size;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  partition_fit_allocator_core DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  logic [1:0]           m_policy;
  bit                   m_dynamic;
  logic [SIZE_W-1:0]    m_memsize;
  logic [ADDR_BITS-1:0] t_base[NPART];
  logic [SIZE_W-1:0]    t_size[NPART];
  logic [OWNER_W-1:0]   t_owner[NPART];
  bit                   t_used[NPART];
  int                   t_count;

  grant_t pending_grants[$];
  int errors = 0;
  int checked = 0;
  int cycles = 0;
  int words_sent = 0;
  int status_seen[4] = '{0, 0, 0, 0};

  function automatic logic [SIZE_W-1:0] sat_add(logic [SIZE_W-1:0] a, logic [SIZE_W-1:0] b);
    logic [SIZE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SIZE_W] ? SZ_MAX : s[SIZE_W-1:0];
  endfunction

  function automatic void drop_entry(int idx);
    for (int k = idx; k + 1 < t_count; k++) begin
      t_base[k] = t_base[k+1];
      t_size[k] = t_size[k+1];
      t_owner[k] = t_owner[k+1];
      t_used[k] = t_used[k+1];
    end
    t_count--;
  endfunction

  function automatic void add_entry(int idx, logic [ADDR_BITS-1:0] b, logic [SIZE_W-1:0] s);
    for (int k = t_count; k > idx; k--) begin
      t_base[k] = t_base[k-1];
      t_size[k] = t_size[k-1];
      t_owner[k] = t_owner[k-1];
      t_used[k] = t_used[k-1];
    end
    t_base[idx] = b;
    t_size[idx] = s;
    t_owner[idx] = '0;
    t_used[idx] = 1'b0;
    t_count++;
  endfunction

  function automatic grant_t predict_grant(op_t op, logic [SIZE_W-1:0] req,
                                           logic [OWNER_W-1:0] pid);
    grant_t g;
    bit hit;
    int pick;
    bit pf, nf;
    g = '{STS_OK, '0, '0};
    hit = 0;
    pick = 0;
    case (op)
      OP_INIT: begin
        for (int k = 0; k < NPART; k++) t_used[k] = 1'b0;
        if (m_dynamic) begin
          t_base[0] = '0;
          t_size[0] = m_memsize;
          t_owner[0] = '0;
          t_count = 1;
          g.size = m_memsize;
        end else begin
          t_count = 0;
        end
      end
      OP_APPEND: begin
        if (t_count >= NPART) begin
          g.st = STS_FULL;
        end else begin
          g.base = (t_count > 0) ? t_base[t_count-1] + t_size[t_count-1][ADDR_BITS-1:0] : '0;
          add_entry(t_count, g.base, req);
          g.size = req;
        end
      end
      OP_ALLOC: begin
        for (int k = 0; k < t_count; k++) begin
          if (t_used[k] || req > t_size[k]) continue;
          if (!hit) begin
            hit = 1;
            pick = k;
            if (m_policy != POL_BEST && m_policy != POL_WORST) break;
          end else if (m_policy == POL_BEST && t_size[k] < t_size[pick]) begin
            pick = k;
          end else if (m_policy == POL_WORST && t_size[k] > t_size[pick]) begin
            pick = k;
          end
        end
        if (!hit) begin
          g.st = STS_NO_FIT;
        end else if (m_dynamic && t_size[pick] > req && t_count >= NPART) begin
          g.st = STS_FULL;
        end else begin
          if (m_dynamic && t_size[pick] > req) begin
            add_entry(pick + 1, t_base[pick] + req[ADDR_BITS-1:0], t_size[pick] - req);
            t_size[pick] = req;
          end
          t_used[pick] = 1'b1;
          t_owner[pick] = pid;
          g.base = t_base[pick];
          g.size = t_size[pick];
        end
      end
      default: begin
        for (int k = 0; k < t_count; k++)
          if (t_used[k] && t_owner[k] == pid) begin
            hit = 1;
            pick = k;
            break;
          end
        if (!hit) begin
          g.st = STS_NOT_FOUND;
        end else begin
          t_used[pick] = 1'b0;
          g.base = t_base[pick];
          g.size = t_size[pick];
          if (m_dynamic && t_count >= 2) begin
            pf = pick > 0 && !t_used[pick-1];
            nf = pick + 1 < t_count && !t_used[pick+1];
            if (pf && nf) begin
              t_size[pick-1] = sat_add(sat_add(t_size[pick-1], t_size[pick]), t_size[pick+1]);
              drop_entry(pick + 1);
              drop_entry(pick);
            end else if (nf) begin
              t_size[pick] = sat_add(t_size[pick], t_size[pick+1]);
              drop_entry(pick + 1);
            end else if (pf) begin
              t_size[pick-1] = sat_add(t_size[pick-1], t_size[pick]);
              drop_entry(pick);
            end
          end
        end
      end
    endcase
    return g;
  endfunction

  // the triple sum above saturates at each step, while the RTL saturates the exact
  // sum once (sat of a+b then +c equals sat of a+b+c for non-negative terms)

  always @(posedge clk) begin
    grant_t want;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (pending_grants.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word st=%0d base=%0h size=%0h",
                                   out_status, out_granted_base, out_granted_size);
      end else begin
        want = pending_grants.pop_front();
        checked++;
        status_seen[out_status]++;
        if (out_status !== want.st || out_granted_base !== want.base ||
            out_granted_size !== want.size) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st=%0d base=%0h size=%0h got st=%0d base=%0h size=%0h",
                     want.st, want.base, want.size, out_status, out_granted_base,
                     out_granted_size);
        end
      end
    end
    if (cycles >= LIMIT) begin
      $display("timeout with %0d words outstanding", pending_grants.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FIT_POLICY: m_policy = val[1:0];
      REG_DYNAMIC_SCHEME: m_dynamic = val[0];
      REG_MEMORY_SIZE: m_memsize = val[SIZE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic settle();
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_word(op_t op, logic [SIZE_W-1:0] req, logic [OWNER_W-1:0] pid,
                           bit typed, grant_t want, bit gaps);
    grant_t g;
    if (gaps) repeat ($urandom_range(0, 8)) @(posedge clk);
    start <= 1'b1;
    in_operation <= op;
    in_request_size <= req;
    in_process_id <= pid;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    g = predict_grant(op, req, pid);
    if (typed && g != want) begin
      errors++;
      if (errors <= 10) $display("table row disagrees with model for op %0d", op);
    end
    pending_grants.push_back(g);
    words_sent++;
    @(posedge clk);
  endtask

  function automatic logic [SIZE_W-1:0] rand_size(logic [SIZE_W-1:0] span);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SZ_MAX;
      2: return SIZE_W'($urandom_range(0, 21'h100000));
      default: return SIZE_W'($urandom_range(0, span));
    endcase
  endfunction

  row_t rows[$];
  grant_t ok0 = '{STS_OK, '0, '0};

  initial begin
    logic [OWNER_W-1:0] pid;
    op_t op;
    m_policy = POL_FIRST;
    m_dynamic = 1;
    m_memsize = SIZE_W'(DEF_MEMORY_SIZE);
    t_count = 0;
    for (int k = 0; k < NPART; k++) t_used[k] = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset defaults, errors on empty table, fills and extremes
    rows.push_back('{OP_ALLOC, 21'd1, 16'd1, 1, '{STS_NO_FIT, '0, '0}});
    rows.push_back('{OP_FREE, 21'd0, 16'hFFFF, 1, '{STS_NOT_FOUND, '0, '0}});
    rows.push_back('{OP_INIT, 21'd0, 16'd0, 1, '{STS_OK, '0, 21'd4096}});
    rows.push_back('{OP_ALLOC, 21'd0, 16'd7, 1, '{STS_OK, '0, '0}});
    rows.push_back('{OP_ALLOC, 21'd100, 16'hFFFF, 1, '{STS_OK, '0, 21'd100}});
    rows.push_back('{OP_ALLOC, 21'd4000, 16'd2, 1, '{STS_NO_FIT, '0, '0}});
    rows.push_back('{OP_ALLOC, 21'd3996, 16'd3, 1, '{STS_OK, 20'd100, 21'd3996}});
    rows.push_back('{OP_FREE, 21'd0, 16'hFFFF, 1, '{STS_OK, '0, 21'd100}});
    rows.push_back('{OP_FREE, 21'd0, 16'd7, 1, '{STS_OK, '0, '0}});
    rows.push_back('{OP_APPEND, 21'h1FFFFF, 16'd0, 1, '{STS_OK, 20'd4096, 21'h1FFFFF}});
    rows.push_back('{OP_FREE, 21'd0, 16'd3, 0, ok0});
    for (int k = 0; k < 14; k++) rows.push_back('{OP_ALLOC, 21'd1, 16'(k), 0, ok0});
    foreach (rows[r]) send_word(rows[r].op, rows[r].req, rows[r].pid, rows[r].typed,
                                rows[r].want, 0);
    settle();

    // random phases over several register settings
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_FIT_POLICY, CFG_W'(ph % 4));
      write_reg(REG_DYNAMIC_SCHEME, CFG_W'((ph % 3) != 2));
      case (ph % 4)
        0: write_reg(REG_MEMORY_SIZE, 21'd1);
        1: write_reg(REG_MEMORY_SIZE, 21'h100000);
        2: write_reg(REG_MEMORY_SIZE, 21'h1FFFFF);
        default: write_reg(REG_MEMORY_SIZE, CFG_W'($urandom_range(1, 65536)));
      endcase
      send_word(OP_INIT, rand_size(21'h1FFFFF), 16'($urandom), 0, ok0, 1);
      if (!m_dynamic)
        repeat ($urandom_range(2, 17)) send_word(OP_APPEND, rand_size(4096), '0, 0, ok0, 1);
      for (int n = 0; n < 78; n++) begin
        pid = 16'($urandom_range(0, 11));
        if ($urandom_range(0, 19) == 0) pid = 16'($urandom);
        case ($urandom_range(0, 19))
          0: op = OP_INIT;
          1, 2: op = OP_APPEND;
          3, 4, 5, 6, 7, 8, 9, 10, 11: op = OP_ALLOC;
          default: op = OP_FREE;
        endcase
        send_word(op, rand_size(m_memsize >> 3), pid, 0, ok0, ($urandom_range(0, 3) != 0));
      end
      settle();
    end

    settle();
    $display("%0d command words sent, %0d results checked", words_sent, checked);
    $display("statuses ok/no-fit/not-found/full: %0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0 && pending_grants.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* partition_fit_allocator_core.f */
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_cell.sv
hw/rtl/partition_fit_allocator_core.sv
dv/testbench.sv
